// ----- src/midi_track_event_parser_assert.svh -----
// Assertion macros for the MIDI track event parser.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mtp_pkg.sv -----
// Shared types and constants of the MIDI track event parser.
// No dependencies; used by every module of the block.
package mtp_pkg;

  // Record kinds as they appear on the result port.
  localparam logic [3:0] KIND_NOTEOFF   = 4'd0;
  localparam logic [3:0] KIND_NOTEON    = 4'd1;
  localparam logic [3:0] KIND_POLYTOUCH = 4'd2;
  localparam logic [3:0] KIND_CONTROL   = 4'd3;
  localparam logic [3:0] KIND_PROGRAM   = 4'd4;
  localparam logic [3:0] KIND_CHANPRESS = 4'd5;
  localparam logic [3:0] KIND_BEND      = 4'd6;
  localparam logic [3:0] KIND_SYSEX     = 4'd7;
  localparam logic [3:0] KIND_SYSEXPKT  = 4'd8;
  localparam logic [3:0] KIND_META      = 4'd9;
  localparam logic [3:0] KIND_PAYLOAD   = 4'd10;
  localparam logic [3:0] KIND_ENDTRACK  = 4'd11;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd12;
  localparam logic [3:0] KIND_TRUNC     = 4'd13;

  // Status bytes and status high nibbles.
  localparam logic [7:0] STAT_SYSEX      = 8'hF0;
  localparam logic [7:0] STAT_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] STAT_META       = 8'hFF;
  localparam logic [7:0] META_EOT        = 8'h2F;
  localparam logic [3:0] HI_PROGRAM      = 4'hC;
  localparam logic [3:0] HI_CHANPRESS    = 4'hD;
  localparam logic [3:0] HI_BEND         = 4'hE;
  localparam logic [3:0] HI_SYSTEM       = 4'hF;

  // Fixed widths of the result fields.
  localparam int TRACK_W = 16;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 28;
  localparam int VAL2_W  = 14;

  // Record queue between parser and output stage; depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Raw record from the parser; the output stage shapes it into port fields.
  typedef struct packed {
    logic [3:0]       kind;
    logic [TIME_W-1:0] abs_time;
    logic [3:0]       chan;
    logic [7:0]       d1;
    logic [7:0]       d2;
    logic [LEN_W-1:0] len;
    logic             last;
  } mtp_rec_t;

endpackage

// ----- src/mtp_front.sv -----
// Byte parser of the MIDI track event parser: delta times, running status,
// event decode. Emits raw records; depends on mtp_pkg.
module mtp_front
  import mtp_pkg::*;
#(
  parameter int TIME_BITS   = 32,
  parameter int LENGTH_BITS = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_chunk,
  output logic       rec_push,
  output mtp_rec_t   rec
);

  localparam logic [3:0] PH_DELTA      = 4'd0;
  localparam logic [3:0] PH_DELTA_MORE = 4'd1;
  localparam logic [3:0] PH_STATUS     = 4'd2;
  localparam logic [3:0] PH_DATA1      = 4'd3;
  localparam logic [3:0] PH_DATA2      = 4'd4;
  localparam logic [3:0] PH_SXLEN      = 4'd5;
  localparam logic [3:0] PH_METATYPE   = 4'd6;
  localparam logic [3:0] PH_METALEN    = 4'd7;
  localparam logic [3:0] PH_PAYLOAD    = 4'd8;

  logic [3:0]             phase_r, phase_nxt;
  logic [7:0]             run_stat_r, run_stat_nxt;
  logic [7:0]             cur_stat_r, cur_stat_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [LENGTH_BITS-1:0] vlq_r, vlq_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [7:0]             meta_r, meta_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic                   fin_r, fin_nxt;

  logic [LENGTH_BITS+6:0]           vlq_cat;
  logic [LENGTH_BITS-1:0]           vlq_shift;
  logic [TIME_BITS+LENGTH_BITS-1:0] sum_wide;
  logic [LENGTH_BITS-1:0]           remain_dec;

  assign vlq_cat    = {vlq_r, data_byte[6:0]};
  assign vlq_shift  = vlq_cat[LENGTH_BITS-1:0];
  assign sum_wide   = {{LENGTH_BITS{1'b0}}, time_r} + {{TIME_BITS{1'b0}}, vlq_shift};
  assign remain_dec = remain_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    logic                   emit;
    logic [3:0]             e_kind;
    logic [3:0]             e_chan;
    logic [7:0]             e_d1;
    logic [7:0]             e_d2;
    logic [LENGTH_BITS-1:0] e_len;
    logic                   e_last;
    logic                   do_first;
    logic                   do_hdr;
    logic [3:0]             hdr_kind;
    logic [7:0]             hdr_d1;
    logic [TIME_BITS-1:0]   time_rec;
    logic [TIME_BITS+TIME_W-1:0] time_wide;
    logic [LENGTH_BITS+LEN_W-1:0] len_wide;

    phase_nxt    = phase_r;
    run_stat_nxt = run_stat_r;
    cur_stat_nxt = cur_stat_r;
    time_nxt     = time_r;
    vlq_nxt      = vlq_r;
    held_nxt     = held_r;
    meta_nxt     = meta_r;
    remain_nxt   = remain_r;
    fin_nxt      = fin_r;
    emit         = 1'b0;
    e_kind       = KIND_UNKNOWN;
    e_d1         = 8'd0;
    e_d2         = 8'd0;
    e_len        = '0;
    e_last       = 1'b1;
    do_first     = 1'b0;
    do_hdr       = 1'b0;
    hdr_kind     = KIND_SYSEX;
    hdr_d1       = 8'd0;

    if (!fin_r) begin
      case (phase_r)
        PH_DELTA, PH_DELTA_MORE: begin
          vlq_nxt = vlq_shift;
          if (!data_byte[7]) begin
            time_nxt  = sum_wide[TIME_BITS-1:0];
            vlq_nxt   = '0;
            phase_nxt = PH_STATUS;
          end else begin
            phase_nxt = PH_DELTA_MORE;
          end
        end
        PH_STATUS: begin
          if (data_byte[7]) begin
            cur_stat_nxt = data_byte;
            if (data_byte[7:4] != HI_SYSTEM) begin
              run_stat_nxt = data_byte;
              phase_nxt    = PH_DATA1;
            end else if (data_byte == STAT_SYSEX || data_byte == STAT_SYSEX_CONT) begin
              vlq_nxt   = '0;
              phase_nxt = PH_SXLEN;
            end else if (data_byte == STAT_META) begin
              phase_nxt = PH_METATYPE;
            end else begin
              emit      = 1'b1;
              e_kind    = KIND_UNKNOWN;
              e_d1      = data_byte;
              phase_nxt = PH_DELTA;
            end
          end else begin
            cur_stat_nxt = run_stat_r;
            if (!run_stat_r[7]) begin
              // Data byte with no running status in force.
              emit      = 1'b1;
              e_kind    = KIND_UNKNOWN;
              e_d1      = run_stat_r;
              phase_nxt = PH_DELTA;
            end else begin
              do_first = 1'b1;
            end
          end
        end
        PH_DATA1: begin
          do_first = 1'b1;
        end
        PH_DATA2: begin
          emit = 1'b1;
          if (cur_stat_r[7:4] == HI_BEND) begin
            e_kind = KIND_BEND;
          end else begin
            // Channel status nibbles 8..B map onto kinds 0..3.
            e_kind = {1'b0, cur_stat_r[6:4]};
          end
          e_d1      = held_r;
          e_d2      = data_byte;
          phase_nxt = PH_DELTA;
        end
        PH_SXLEN: begin
          vlq_nxt = vlq_shift;
          if (!data_byte[7]) begin
            do_hdr   = 1'b1;
            hdr_kind = (cur_stat_r == STAT_SYSEX_CONT) ? KIND_SYSEXPKT : KIND_SYSEX;
          end
        end
        PH_METATYPE: begin
          meta_nxt  = data_byte;
          vlq_nxt   = '0;
          phase_nxt = PH_METALEN;
        end
        PH_METALEN: begin
          vlq_nxt = vlq_shift;
          if (!data_byte[7]) begin
            if (meta_r == META_EOT) begin
              emit      = 1'b1;
              e_kind    = KIND_ENDTRACK;
              e_d1      = meta_r;
              e_len     = vlq_shift;
              vlq_nxt   = '0;
              fin_nxt   = 1'b1;
              phase_nxt = PH_DELTA;
            end else begin
              do_hdr   = 1'b1;
              hdr_kind = KIND_META;
              hdr_d1   = meta_r;
            end
          end
        end
        default: begin
          remain_nxt = remain_dec;
          emit       = 1'b1;
          e_kind     = KIND_PAYLOAD;
          e_d1       = data_byte;
          e_last     = (remain_dec == '0);
          if (remain_dec == '0) begin
            phase_nxt = PH_DELTA;
          end
        end
      endcase
    end

    if (do_first) begin
      if (cur_stat_nxt[7:4] == HI_PROGRAM || cur_stat_nxt[7:4] == HI_CHANPRESS) begin
        emit      = 1'b1;
        e_kind    = {1'b0, cur_stat_nxt[6:4]};
        e_d1      = data_byte;
        phase_nxt = PH_DELTA;
      end else begin
        held_nxt  = data_byte;
        phase_nxt = PH_DATA2;
      end
    end

    if (do_hdr) begin
      emit       = 1'b1;
      e_kind     = hdr_kind;
      e_d1       = hdr_d1;
      e_len      = vlq_shift;
      e_last     = (vlq_shift == '0);
      remain_nxt = vlq_shift;
      vlq_nxt    = '0;
      phase_nxt  = (vlq_shift == '0) ? PH_DELTA : PH_PAYLOAD;
    end

    // Time and channel are taken before the end of a chunk clears the state.
    time_rec = time_nxt;
    e_chan   = cur_stat_nxt[3:0];

    if (end_of_chunk) begin
      // A chunk that stops inside an event reports that instead.
      if (!fin_nxt && phase_nxt != PH_DELTA) begin
        emit   = 1'b1;
        e_kind = KIND_TRUNC;
        e_d1   = 8'd0;
        e_d2   = 8'd0;
        e_len  = '0;
        e_last = 1'b1;
      end
      phase_nxt    = PH_DELTA;
      run_stat_nxt = 8'd0;
      cur_stat_nxt = 8'd0;
      time_nxt     = '0;
      vlq_nxt      = '0;
      held_nxt     = 8'd0;
      meta_nxt     = 8'd0;
      remain_nxt   = '0;
      fin_nxt      = 1'b0;
    end

    time_wide = {{TIME_W{1'b0}}, time_rec};
    len_wide  = {{LEN_W{1'b0}}, e_len};

    rec_push      = accept && emit;
    rec.kind      = e_kind;
    rec.abs_time  = time_wide[TIME_W-1:0];
    rec.chan      = e_chan;
    rec.d1        = e_d1;
    rec.d2        = e_d2;
    rec.len       = len_wide[LEN_W-1:0];
    rec.last      = e_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DELTA;
      run_stat_r <= 8'd0;
      cur_stat_r <= 8'd0;
      time_r     <= '0;
      vlq_r      <= '0;
      held_r     <= 8'd0;
      meta_r     <= 8'd0;
      remain_r   <= '0;
      fin_r      <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      run_stat_r <= run_stat_nxt;
      cur_stat_r <= cur_stat_nxt;
      time_r     <= time_nxt;
      vlq_r      <= vlq_nxt;
      held_r     <= held_nxt;
      meta_r     <= meta_nxt;
      remain_r   <= remain_nxt;
      fin_r      <= fin_nxt;
    end
  end

endmodule

// ----- src/mtp_queue.sv -----
// Short record queue between the parser and the output stage.
// Flip-flop storage of QUEUE_DEPTH entries; depends on mtp_pkg.
module mtp_queue
  import mtp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mtp_rec_t push_rec,
  input  logic     pop,
  output mtp_rec_t head,
  output logic     full,
  output logic     empty
);

  mtp_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- src/mtp_back.sv -----
// Output stage: drains the record queue, shapes raw records into port
// fields and holds the current result. Depends on mtp_pkg.
module mtp_back
  import mtp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mtp_rec_t           q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [TRACK_W-1:0] track_number,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_record_kind,
  output logic [TRACK_W-1:0] out_track_id,
  output logic [TIME_W-1:0]  out_abs_time,
  output logic [3:0]         out_channel,
  output logic [7:0]         out_first_value,
  output logic [VAL2_W-1:0]  out_second_value,
  output logic [LEN_W-1:0]   out_payload_length,
  output logic               out_last_of_event
);

  logic               valid_r, valid_nxt;
  logic [3:0]         kind_r;
  logic [TRACK_W-1:0] track_r;
  logic [TIME_W-1:0]  time_r;
  logic [3:0]         chan_r, chan_nxt;
  logic [7:0]         first_r, first_nxt;
  logic [VAL2_W-1:0]  second_r, second_nxt;
  logic [LEN_W-1:0]   len_r;
  logic               last_r;
  logic               load;

  // The register takes a new beat whenever it is free or being emptied.
  assign load      = !q_empty && (!valid_r || out_pop);
  assign q_pop     = load;
  assign valid_nxt = load || (valid_r && !out_pop);

  always_comb begin
    chan_nxt   = (q_head.kind <= KIND_BEND) ? q_head.chan : 4'd0;
    first_nxt  = (q_head.kind == KIND_BEND) ? 8'd0 : q_head.d1;
    if (q_head.kind == KIND_BEND) begin
      second_nxt = {q_head.d2[6:0], q_head.d1[6:0]};
    end else if (q_head.kind <= KIND_CONTROL) begin
      second_nxt = {{(VAL2_W-8){1'b0}}, q_head.d2};
    end else begin
      second_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= q_head.kind;
      track_r  <= track_number;
      time_r   <= q_head.abs_time;
      chan_r   <= chan_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      len_r    <= q_head.len;
      last_r   <= q_head.last;
    end
  end

  assign out_empty          = !valid_r;
  assign out_record_kind    = kind_r;
  assign out_track_id       = track_r;
  assign out_abs_time       = time_r;
  assign out_channel        = chan_r;
  assign out_first_value    = first_r;
  assign out_second_value   = second_r;
  assign out_payload_length = len_r;
  assign out_last_of_event  = last_r;

endmodule

// ----- src/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser: track register, parser, queue
// and output stage. Depends on mtp_pkg, mtp_front, mtp_queue, mtp_back.
//
// Feed the bytes of one track chunk through the in_ queue port, one beat
// per byte, with in_end_of_chunk set on the last byte; records come out of
// the out_ queue port in order. The parser decodes each byte
// combinationally, so one byte is taken per clock as long as the four-entry
// record queue has room; a record passes from that queue into the output
// register, and so onto the result ports, when that register is free. in_full
// rises only when that queue is full, which happens when the consumer stops
// popping. Write the track number on the cfg_ port (always ready) between
// chunks; it resets to 1.
module midi_track_event_parser
  import mtp_pkg::*;
#(
  parameter int TIME_BITS   = 32,
  parameter int LENGTH_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_chunk,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [3:0]         out_record_kind,
  output logic [TRACK_W-1:0] out_track_id,
  output logic [TIME_W-1:0]  out_abs_time,
  output logic [3:0]         out_channel,
  output logic [7:0]         out_first_value,
  output logic [VAL2_W-1:0]  out_second_value,
  output logic [LEN_W-1:0]   out_payload_length,
  output logic               out_last_of_event,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TRACK_W-1:0] cfg_track_number
);

`include "midi_track_event_parser_assert.svh"

  logic [TRACK_W-1:0] track_r;
  logic               accept;
  logic               rec_push;
  mtp_rec_t           rec;
  mtp_rec_t           q_head;
  logic               q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= TRACK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      track_r <= cfg_track_number;
    end
  end

  mtp_front #(
    .TIME_BITS   (TIME_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_chunk (in_end_of_chunk),
    .rec_push     (rec_push),
    .rec          (rec)
  );

  mtp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mtp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .track_number       (track_r),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_record_kind    (out_record_kind),
    .out_track_id       (out_track_id),
    .out_abs_time       (out_abs_time),
    .out_channel        (out_channel),
    .out_first_value    (out_first_value),
    .out_second_value   (out_second_value),
    .out_payload_length (out_payload_length),
    .out_last_of_event  (out_last_of_event)
  );

  // Only channel messages carry a channel.
  `MTP_ASSERT_NOW(a_chan_only_channel_msgs, !out_empty && out_record_kind > KIND_BEND, out_channel == 4'd0, "channel set on a non-channel record")

  // Only sysex, meta and end-of-track headers carry a length.
  `MTP_ASSERT_NOW(a_len_only_headers, !out_empty && out_payload_length != '0, out_record_kind == KIND_SYSEX || out_record_kind == KIND_SYSEXPKT || out_record_kind == KIND_META || out_record_kind == KIND_ENDTRACK, "length set on a non-header record")

  // A popped result with nothing queued behind it leaves the port empty.
  `MTP_ASSERT_NEXT(a_drain_to_empty, !out_empty && out_pop && q_empty, out_empty, "result appeared without a queued record")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for midi_track_event_parser: streams track-chunk bytes
// through the input queue port and checks every record against a predictor.
// Depends on mtp_pkg and the parser RTL only.
module tb_top;
  import mtp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 60;
  localparam int RANDOM_BYTES  = 1850;
  localparam logic [3:0] HI_NOTEOFF = 4'h8;

  typedef enum logic [3:0] {
    PH_DELTA, PH_DELTA_MORE, PH_STATUS, PH_DATA1, PH_DATA2,
    PH_SXLEN, PH_METATYPE, PH_METALEN, PH_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [TRACK_W-1:0] track;
    logic [TIME_W-1:0] abs_time;
    logic [3:0]        chan;
    logic [7:0]        v1;
    logic [VAL2_W-1:0] v2;
    logic [LEN_W-1:0]  len;
    logic              last;
  } midi_rec_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_end_of_chunk = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [3:0]         out_record_kind;
  logic [TRACK_W-1:0] out_track_id;
  logic [TIME_W-1:0]  out_abs_time;
  logic [3:0]         out_channel;
  logic [7:0]         out_first_value;
  logic [VAL2_W-1:0]  out_second_value;
  logic [LEN_W-1:0]   out_payload_length;
  logic               out_last_of_event;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TRACK_W-1:0] cfg_track_number = '0;

  midi_track_event_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_end_of_chunk   (in_end_of_chunk),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_record_kind   (out_record_kind),
    .out_track_id      (out_track_id),
    .out_abs_time      (out_abs_time),
    .out_channel       (out_channel),
    .out_first_value   (out_first_value),
    .out_second_value  (out_second_value),
    .out_payload_length(out_payload_length),
    .out_last_of_event (out_last_of_event),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_track_number  (cfg_track_number)
  );

  // Predictor state, mirrors the parser's architectural state.
  logic [TRACK_W-1:0] trk_num;
  parse_phase_t       phase;
  logic [7:0]         run_status;
  logic [7:0]         cur_status;
  logic [TIME_W-1:0]  time_total;
  logic [LEN_W-1:0]   vlq_acc;
  logic [7:0]         held_byte;
  logic [7:0]         meta_type;
  logic [LEN_W-1:0]   bytes_left;
  logic               trk_done;

  midi_rec_t pending_records[$];
  midi_rec_t oldest_rec;
  logic [7:0] chunk_bytes[$];
  logic [7:0] gen_status;

  int err_count       = 0;
  int records_checked = 0;
  int bytes_sent      = 0;
  int chunk_count     = 0;
  int cfg_writes      = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  bit idle_on         = 1'b1;
  int stall_tick      = 0;
  int stall_mode      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (record %0d)",
               what, got, want, records_checked);
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic clear_chunk_state();
    phase      = PH_DELTA;
    run_status = '0;
    cur_status = '0;
    time_total = '0;
    vlq_acc    = '0;
    held_byte  = '0;
    meta_type  = '0;
    bytes_left = '0;
    trk_done   = 1'b0;
  endtask

  function automatic midi_rec_t make_rec(input logic [3:0] kind, input logic [3:0] chan,
                                         input logic [7:0] v1, input logic [VAL2_W-1:0] v2,
                                         input logic [LEN_W-1:0] len, input logic last);
    midi_rec_t r;
    r.kind     = kind;
    r.track    = trk_num;
    r.abs_time = time_total;
    r.chan     = chan;
    r.v1       = v1;
    r.v2       = v2;
    r.len      = len;
    r.last     = last;
    return r;
  endfunction

  // Shifts one 7-bit group in; high bits fall off the top of the accumulator.
  function automatic bit vlq_shift(input logic [7:0] b);
    vlq_acc = {vlq_acc[LEN_W-8:0], b[6:0]};
    return !b[7];
  endfunction

  task automatic first_data(input logic [7:0] b, output midi_rec_t rec, output bit have_rec);
    rec = '0;
    have_rec = 1'b0;
    if (cur_status[7:4] == HI_PROGRAM || cur_status[7:4] == HI_CHANPRESS) begin
      rec = make_rec(cur_status[7:4] - HI_NOTEOFF, cur_status[3:0], b, '0, '0, 1'b1);
      have_rec = 1'b1;
      phase = PH_DELTA;
    end else begin
      held_byte = b;
      phase = PH_DATA2;
    end
  endtask

  task automatic start_payload(input logic [3:0] kind, input logic [7:0] v1,
                               output midi_rec_t rec);
    rec = make_rec(kind, '0, v1, '0, vlq_acc, vlq_acc == '0);
    bytes_left = vlq_acc;
    if (vlq_acc == '0) phase = PH_DELTA;
    else phase = PH_PAYLOAD;
    vlq_acc = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoc);
    midi_rec_t rec;
    bit have_rec;
    rec = '0;
    have_rec = 1'b0;
    if (!trk_done) begin
      case (phase)
        PH_DELTA, PH_DELTA_MORE: begin
          if (vlq_shift(b)) begin
            time_total = time_total + TIME_W'(vlq_acc);
            vlq_acc = '0;
            phase = PH_STATUS;
          end else begin
            phase = PH_DELTA_MORE;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            cur_status = b;
            if (b[7:4] != HI_SYSTEM) begin
              run_status = b;
              phase = PH_DATA1;
            end else if (b == STAT_SYSEX || b == STAT_SYSEX_CONT) begin
              vlq_acc = '0;
              phase = PH_SXLEN;
            end else if (b == STAT_META) begin
              phase = PH_METATYPE;
            end else begin
              rec = make_rec(KIND_UNKNOWN, '0, b, '0, '0, 1'b1);
              have_rec = 1'b1;
              phase = PH_DELTA;
            end
          end else begin
            // Running status covers channel messages only.
            cur_status = run_status;
            if (!run_status[7]) begin
              rec = make_rec(KIND_UNKNOWN, '0, run_status, '0, '0, 1'b1);
              have_rec = 1'b1;
              phase = PH_DELTA;
            end else begin
              first_data(b, rec, have_rec);
            end
          end
        end
        PH_DATA1: first_data(b, rec, have_rec);
        PH_DATA2: begin
          if (cur_status[7:4] == HI_BEND)
            rec = make_rec(KIND_BEND, cur_status[3:0], '0, {b[6:0], held_byte[6:0]}, '0, 1'b1);
          else
            rec = make_rec(cur_status[7:4] - HI_NOTEOFF, cur_status[3:0], held_byte,
                           VAL2_W'(b), '0, 1'b1);
          have_rec = 1'b1;
          phase = PH_DELTA;
        end
        PH_SXLEN: begin
          if (vlq_shift(b)) begin
            start_payload(cur_status == STAT_SYSEX_CONT ? KIND_SYSEXPKT : KIND_SYSEX,
                          '0, rec);
            have_rec = 1'b1;
          end
        end
        PH_METATYPE: begin
          meta_type = b;
          vlq_acc = '0;
          phase = PH_METALEN;
        end
        PH_METALEN: begin
          if (vlq_shift(b)) begin
            if (meta_type == META_EOT) begin
              rec = make_rec(KIND_ENDTRACK, '0, meta_type, '0, vlq_acc, 1'b1);
              vlq_acc = '0;
              trk_done = 1'b1;
              phase = PH_DELTA;
            end else begin
              start_payload(KIND_META, meta_type, rec);
            end
            have_rec = 1'b1;
          end
        end
        default: begin
          bytes_left = bytes_left - 1'b1;
          rec = make_rec(KIND_PAYLOAD, '0, b, '0, '0, bytes_left == '0);
          have_rec = 1'b1;
          if (bytes_left == '0) phase = PH_DELTA;
        end
      endcase
    end
    if (eoc) begin
      // A chunk cut off inside an event reports truncation instead.
      if (!trk_done && phase != PH_DELTA) begin
        rec = make_rec(KIND_TRUNC, '0, '0, '0, '0, 1'b1);
        have_rec = 1'b1;
      end
      clear_chunk_state();
    end
    if (have_rec) pending_records.push_back(rec);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic eoc);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_data_byte    <= b;
    in_end_of_chunk <= eoc;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_byte(b, eoc);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_chunk();
    foreach (chunk_bytes[i]) send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    chunk_bytes.delete();
    chunk_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    // Bytes that give no record may still be inside the parser.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_track_number(input logic [TRACK_W-1:0] value);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_track_number <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk_num = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The receiver switches at random among stall patterns.
  always @(negedge clk) begin
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 3) != 0);
      2: out_pop <= (stall_tick % 16 >= 10);
      default: out_pop <= $urandom_range(0, 1);
    endcase
  end

  // Each popped beat is compared with the oldest predicted record.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record, kind", out_record_kind, 32'd0);
      end else begin
        oldest_rec = pending_records.pop_front();
        if (out_record_kind !== oldest_rec.kind)
          report_mismatch("record_kind", out_record_kind, oldest_rec.kind);
        if (out_track_id !== oldest_rec.track)
          report_mismatch("track_id", out_track_id, oldest_rec.track);
        if (out_abs_time !== oldest_rec.abs_time)
          report_mismatch("abs_time", out_abs_time, oldest_rec.abs_time);
        if (out_channel !== oldest_rec.chan)
          report_mismatch("channel", out_channel, oldest_rec.chan);
        if (out_first_value !== oldest_rec.v1)
          report_mismatch("first_value", out_first_value, oldest_rec.v1);
        if (out_second_value !== oldest_rec.v2)
          report_mismatch("second_value", out_second_value, oldest_rec.v2);
        if (out_payload_length !== oldest_rec.len)
          report_mismatch("payload_length", out_payload_length, oldest_rec.len);
        if (out_last_of_event !== oldest_rec.last)
          report_mismatch("last_of_event", out_last_of_event, oldest_rec.last);
      end
      records_checked++;
    end
  end

  // ---------------------------------------------------------------- generators

  task automatic push_vlq(input logic [LEN_W-1:0] value, input int pad);
    logic [7:0] groups[$];
    logic [LEN_W-1:0] rest;
    rest = value;
    groups.push_front({1'b0, rest[6:0]});
    rest = rest >> 7;
    while (rest != '0) begin
      groups.push_front({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    repeat (pad) chunk_bytes.push_back(8'h80);
    foreach (groups[i]) chunk_bytes.push_back(groups[i]);
  endtask

  task automatic push_delta(input bit wrap_mode);
    int sel;
    logic [LEN_W-1:0] value;
    sel = $urandom_range(0, 19);
    if (wrap_mode) value = LEN_W'($urandom_range(28'h8000000, 28'hFFFFFFF));
    else if (sel < 14) value = LEN_W'($urandom_range(0, 127));
    else if (sel < 18) value = LEN_W'($urandom_range(128, 16383));
    else value = LEN_W'($urandom);
    // An extra leading group adds high bits; they fall off the accumulator only if four or more groups follow it.
    if ($urandom_range(0, 9) == 0) chunk_bytes.push_back({1'b1, 7'($urandom)});
    push_vlq(value, $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0);
  endtask

  function automatic logic [7:0] data_value();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic push_payload(input int len);
    repeat (len) chunk_bytes.push_back(8'($urandom));
  endtask

  task automatic add_event(inout bit rs_ok);
    int pick;
    int len;
    logic [7:0] mtype;
    logic [7:0] stat;
    bit omit;
    pick = $urandom_range(0, 99);
    if (pick < 55 || (pick >= 89 && rs_ok)) begin
      omit = rs_ok && (pick >= 89 || $urandom_range(0, 2) == 0);
      if (!omit) begin
        gen_status = {4'($urandom_range(8, 14)), 4'($urandom)};
        chunk_bytes.push_back(gen_status);
        chunk_bytes.push_back(data_value());
      end else begin
        // Without a status byte the first data byte must look like data.
        chunk_bytes.push_back(8'($urandom_range(0, 127)));
      end
      rs_ok = 1'b1;
      if (gen_status[7:4] != HI_PROGRAM && gen_status[7:4] != HI_CHANPRESS)
        chunk_bytes.push_back(data_value());
    end else if (pick < 68) begin
      chunk_bytes.push_back($urandom_range(0, 1) ? STAT_SYSEX : STAT_SYSEX_CONT);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 6);
      push_vlq(LEN_W'(len), $urandom_range(0, 7) == 0 ? 1 : 0);
      push_payload(len);
    end else if (pick < 81) begin
      chunk_bytes.push_back(STAT_META);
      do mtype = 8'($urandom); while (mtype == META_EOT);
      chunk_bytes.push_back(mtype);
      len = $urandom_range(0, 6);
      push_vlq(LEN_W'(len), 0);
      push_payload(len);
    end else if (pick < 89) begin
      do stat = 8'($urandom_range(8'hF1, 8'hFE)); while (stat == STAT_SYSEX_CONT);
      chunk_bytes.push_back(stat);
    end else begin
      // Data byte with no running status yet.
      chunk_bytes.push_back(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic build_random_chunk();
    int pick;
    int len;
    int cut;
    bit rs_ok;
    bit wrap_mode;
    chunk_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 30)) chunk_bytes.push_back(8'($urandom));
    end else begin
      // Long chunks of large deltas can carry the absolute time past 2^32.
      wrap_mode = pick < 12;
      rs_ok = 1'b0;
      repeat (wrap_mode ? $urandom_range(17, 24) : $urandom_range(1, 12)) begin
        push_delta(wrap_mode);
        add_event(rs_ok);
      end
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        push_delta(1'b0);
        chunk_bytes.push_back(STAT_META);
        chunk_bytes.push_back(META_EOT);
        len = $urandom_range(0, 2);
        push_vlq(LEN_W'(len), 0);
        push_payload(len + $urandom_range(0, 3));
      end else if (pick == 2) begin
        cut = $urandom_range(1, chunk_bytes.size());
        while (chunk_bytes.size() > cut) void'(chunk_bytes.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_channel_messages();
    // Note on, the same note under running status, a program change after a
    // two-group delta with an unmasked data byte, and a full-scale bend; the
    // chunk ends on an event boundary.
    chunk_bytes = '{8'h00, 8'h90, 8'h3C, 8'h7F,
                    8'h00, 8'h3C, 8'h00,
                    8'h81, 8'h00, 8'hC5, 8'hFF,
                    8'h00, 8'hE3, 8'hFF, 8'hFF};
    send_chunk();
    wait_drained();
  endtask

  task automatic test_odd_status();
    write_track_number(16'hFFFF);
    // Data byte before any channel status, an undefined status, an empty
    // sysex, then an end-of-track event followed by bytes that must be ignored.
    chunk_bytes = '{8'h00, 8'h45,
                    8'h00, 8'hF4,
                    8'h00, STAT_SYSEX, 8'h00,
                    8'h00, STAT_META, META_EOT, 8'h00,
                    8'h12, 8'h34};
    send_chunk();
    wait_drained();
  endtask

  task automatic test_payload_and_truncation();
    write_track_number(16'h0000);
    // Meta with two payload bytes, an oversized delta, and a chunk that ends
    // right after a channel status.
    chunk_bytes = '{8'h00, STAT_META, 8'h01, 8'h02, 8'hAA, 8'h55,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                    8'h9F};
    send_chunk();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    int sel;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
        sel = $urandom_range(0, 3);
        if (sel == 0) write_track_number('0);
        else if (sel == 1) write_track_number('1);
        else write_track_number(TRACK_W'($urandom));
      end
      idle_on = ($urandom_range(0, 3) != 0);
      build_random_chunk();
      send_chunk();
    end
  endtask

  initial begin
    trk_num = 16'd1;
    clear_chunk_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_channel_messages();
    test_odd_status();
    test_payload_and_truncation();
    test_random_traffic();
    wait_drained();
    $display("Sent %0d bytes in %0d chunks, checked %0d records, %0d track number writes.",
             bytes_sent, chunk_count, records_checked, cfg_writes);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d records outstanding.",
             cycle_count, pending_records.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
